>>> rtl/core/completion_deadline_tracker_macros.svh
// Assertion macros shared by the tracker RTL.
`ifndef COMPLETION_DEADLINE_TRACKER_MACROS_SVH
`define COMPLETION_DEADLINE_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
`define CDT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tracker assertion failed");
`define CDT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tracker assertion failed");
`else
`define CDT_ASSERT(lbl, clk, rst_n, prop)
`define CDT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> rtl/core/cdt_pkg.sv
package cdt_pkg;

    localparam int unsigned CfgAddrWidth = 2;

    localparam logic [CfgAddrWidth-1:0] REG_EXPECTED_GENERATION = 2'd0;
    localparam logic [CfgAddrWidth-1:0] REG_SUBMIT_TIME         = 2'd1;
    localparam logic [CfgAddrWidth-1:0] REG_DEADLINE_TIME       = 2'd2;

    localparam logic OP_OBSERVE = 1'b0;

    localparam logic [1:0] QUERY_SUCCESS   = 2'd0;
    localparam logic [1:0] QUERY_NOT_READY = 2'd1;
    localparam logic [1:0] QUERY_ERROR     = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNAVAIL  = 2'd1;
    localparam logic [1:0] ST_PRECOND  = 2'd2;
    localparam logic [1:0] ST_INTERNAL = 2'd3;

    localparam logic [2:0] CAUSE_NONE     = 3'd0;
    localparam logic [2:0] CAUSE_GEN      = 3'd1;
    localparam logic [2:0] CAUSE_INVALID  = 3'd2;
    localparam logic [2:0] CAUSE_QUERY    = 3'd3;
    localparam logic [2:0] CAUSE_DIRTY    = 3'd4;
    localparam logic [2:0] CAUSE_DEVICE   = 3'd5;
    localparam logic [2:0] CAUSE_ENGINE   = 3'd6;
    localparam logic [2:0] CAUSE_DEADLINE = 3'd7;

    typedef struct packed {
        logic        operation;
        logic [63:0] seen_generation;
        logic [1:0]  query_outcome;
        logic        last_error_clean;
        logic [31:0] device_code;
        logic        engine_bad;
        logic [63:0] clock_now;
    } cdt_obs_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  failure_cause;
        logic [31:0] failure_device_code;
        logic        is_completed;
        logic        is_poisoned;
        logic        is_draining;
    } cdt_res_t;

    typedef struct packed {
        logic [CfgAddrWidth-1:0] addr;
        logic [63:0]             wdata;
    } cdt_cfg_t;

endpackage

>>> rtl/core/cdt_channels.sv
interface cdt_obs_if;
    import cdt_pkg::*;
    logic     valid;
    logic     ready;
    cdt_obs_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cdt_res_if;
    import cdt_pkg::*;
    logic     valid;
    logic     ready;
    cdt_res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cdt_cfg_if;
    import cdt_pkg::*;
    logic     valid;
    logic     ready;
    cdt_cfg_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/completion_deadline_tracker.sv
// Completion and deadline tracker for one submitted work item.
// Channel obs carries observations of the completion event (operation 0) and
// deadline checks against a clock value (operation 1). Channel res returns
// exactly one result item per observation, in order, with the status and the
// tracker flags after that item. Channel cfg writes the expected generation,
// the submit time and the deadline time; it is always ready, and writes to
// an index beyond the deadline time are dropped.
// An accepted item is held in an input register and evaluated, and its result
// is registered in the result register. One item is accepted every cycle
// while res is not stalled; the input and result registers together decouple
// the two sides, and the rate is set by the single state update per item.
// When the receiver stalls, the result register holds, the input register
// fills, and obs.ready then drops until res drains.
// Reset clears the flags and the latched first failure, and loads the
// registers with generation 1, submit time 0 and deadline time 1.
`include "completion_deadline_tracker_macros.svh"

module completion_deadline_tracker (
    input  logic        clk,
    input  logic        rst_n,
    cdt_obs_if.sink     obs,
    cdt_res_if.source   res,
    cdt_cfg_if.sink     cfg
);
    import cdt_pkg::*;

    logic [63:0] expected_generation_reg;
    logic [63:0] submit_time_reg;
    logic [63:0] deadline_time_reg;

    logic        done_reg;
    logic        poison_reg;
    logic        drain_reg;
    logic [2:0]  cause_reg;
    logic [31:0] code_reg;

    logic        stage_valid_reg;
    cdt_obs_t    stage_reg;
    logic        res_valid_reg;
    cdt_res_t    res_reg;

    logic        advance;
    logic        fail;
    logic        complete;
    logic [1:0]  status;
    logic [2:0]  fail_cause;
    logic [31:0] fail_code;

    logic        done_next;
    logic        poison_next;
    logic        drain_next;
    logic [2:0]  cause_next;
    logic [31:0] code_next;

    assign advance   = stage_valid_reg && (!res_valid_reg || res.ready);
    assign obs.ready = !stage_valid_reg || advance;
    assign cfg.ready = 1'b1;
    assign res.valid = res_valid_reg;
    assign res.data  = res_reg;

    always_comb
    begin
        fail       = 1'b0;
        complete   = 1'b0;
        status     = ST_OK;
        fail_cause = CAUSE_NONE;
        fail_code  = '0;
        if (done_reg || poison_reg)
        begin
            status = ST_PRECOND;
        end
        else if (stage_reg.operation == OP_OBSERVE)
        begin
            if (stage_reg.seen_generation != expected_generation_reg)
            begin
                fail       = 1'b1;
                fail_cause = CAUSE_GEN;
            end
            else if (stage_reg.query_outcome == QUERY_NOT_READY)
            begin
                if (stage_reg.device_code != '0 || stage_reg.engine_bad
                    || !stage_reg.last_error_clean)
                begin
                    fail       = 1'b1;
                    fail_cause = CAUSE_INVALID;
                    fail_code  = stage_reg.device_code;
                end
                else
                begin
                    status = ST_UNAVAIL;
                end
            end
            else if (stage_reg.query_outcome == QUERY_ERROR)
            begin
                fail       = 1'b1;
                fail_cause = CAUSE_QUERY;
                fail_code  = stage_reg.device_code;
            end
            else if (stage_reg.query_outcome != QUERY_SUCCESS)
            begin
                fail       = 1'b1;
                fail_cause = CAUSE_INVALID;
                fail_code  = stage_reg.device_code;
            end
            else if (!stage_reg.last_error_clean)
            begin
                fail       = 1'b1;
                fail_cause = CAUSE_DIRTY;
                fail_code  = stage_reg.device_code;
            end
            else if (stage_reg.device_code != '0)
            begin
                fail       = 1'b1;
                fail_cause = CAUSE_DEVICE;
                fail_code  = stage_reg.device_code;
            end
            else if (stage_reg.engine_bad)
            begin
                fail       = 1'b1;
                fail_cause = CAUSE_ENGINE;
            end
            else
            begin
                complete = 1'b1;
            end
        end
        else
        begin
            if (stage_reg.clock_now < submit_time_reg)
            begin
                fail       = 1'b1;
                fail_cause = CAUSE_INVALID;
            end
            else if (stage_reg.clock_now < deadline_time_reg)
            begin
                status = ST_UNAVAIL;
            end
            else
            begin
                fail       = 1'b1;
                fail_cause = CAUSE_DEADLINE;
            end
        end
        if (fail)
        begin
            status = ST_INTERNAL;
        end
    end

    always_comb
    begin
        done_next   = done_reg || complete;
        poison_next = poison_reg || fail;
        drain_next  = drain_reg || fail;
        cause_next  = fail ? fail_cause : cause_reg;
        code_next   = fail ? fail_code : code_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_generation_reg <= 64'd1;
            submit_time_reg         <= 64'd0;
            deadline_time_reg       <= 64'd1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.addr)
                REG_EXPECTED_GENERATION: expected_generation_reg <= cfg.data.wdata;
                REG_SUBMIT_TIME:         submit_time_reg         <= cfg.data.wdata;
                REG_DEADLINE_TIME:       deadline_time_reg       <= cfg.data.wdata;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg        <= 1'b0;
            poison_reg      <= 1'b0;
            drain_reg       <= 1'b0;
            cause_reg       <= CAUSE_NONE;
            code_reg        <= '0;
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (obs.ready)
            begin
                stage_valid_reg <= obs.valid;
            end
            if (advance)
            begin
                done_reg      <= done_next;
                poison_reg    <= poison_next;
                drain_reg     <= drain_next;
                cause_reg     <= cause_next;
                code_reg      <= code_next;
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (obs.valid && obs.ready)
        begin
            stage_reg <= obs.data;
        end
        if (advance)
        begin
            res_reg.status              <= status;
            res_reg.failure_cause       <= cause_next;
            res_reg.failure_device_code <= code_next;
            res_reg.is_completed        <= done_next;
            res_reg.is_poisoned         <= poison_next;
            res_reg.is_draining         <= drain_next;
        end
    end

    `CDT_ASSERT(a_poison_sticks, clk, rst_n, poison_reg |=> poison_reg)
    `CDT_ASSERT(a_ok_means_completed, clk, rst_n, (res.valid && res.data.status == ST_OK) |-> res.data.is_completed)
    `CDT_ASSERT(a_internal_means_drain, clk, rst_n, (res.valid && res.data.status == ST_INTERNAL) |-> (res.data.is_poisoned && res.data.is_draining))
    `CDT_ASSERT(a_full_stall_blocks, clk, rst_n, (stage_valid_reg && res_valid_reg && !res.ready) |-> !obs.ready)

endmodule
